// ===== design/coap_message_decoder_assert.svh =====
// Assertion macros for the CoAP message decoder.
`ifndef COAP_MESSAGE_DECODER_ASSERT_SVH
`define COAP_MESSAGE_DECODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CMD_ASSERT_PROP(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("decoder assertion failed");
`define CMD_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("decoder condition must never hold");
`else
`define CMD_ASSERT_PROP(lbl, prop)
`define CMD_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== design/coapmd_pkg.sv =====
// Types and constants shared by the CoAP message decoder modules.
`timescale 1ns / 1ps
package coapmd_pkg;

    typedef enum logic [3:0] {
        PH_HEAD    = 4'd0,
        PH_TOKEN   = 4'd1,
        PH_OPT     = 4'd2,
        PH_DX1     = 4'd3,
        PH_DX2     = 4'd4,
        PH_LX1     = 4'd5,
        PH_LX2     = 4'd6,
        PH_VALUE   = 4'd7,
        PH_PAYLOAD = 4'd8,
        PH_DRAIN   = 4'd9
    } t_phase;

    typedef enum logic [2:0] {
        K_HEADER  = 3'd0,
        K_TOKEN   = 3'd1,
        K_OPTION  = 3'd2,
        K_VALUE   = 3'd3,
        K_PAYLOAD = 3'd4,
        K_STATUS  = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_SHORT   = 3'd1,
        ST_BAD_VERSION = 3'd2,
        ST_BAD_TOKEN   = 3'd3,
        ST_EMPTY_MARK  = 3'd4,
        ST_BAD_OPTION  = 3'd5,
        ST_TOO_MANY    = 3'd6
    } t_status;

    typedef enum logic [0:0] {
        CFG_TOKEN_LIMIT  = 1'b0,
        CFG_OPTION_LIMIT = 1'b1
    } t_cfg_index;

    localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
    localparam logic [3:0]  NIBBLE_EXT8    = 4'd13;
    localparam logic [3:0]  NIBBLE_EXT16   = 4'd14;
    localparam logic [3:0]  NIBBLE_RSVD    = 4'd15;
    localparam logic [15:0] EXT8_BASE      = 16'd13;
    localparam logic [15:0] EXT16_BASE     = 16'd269;
    localparam logic [1:0]  COAP_VERSION   = 2'd1;
    localparam logic [3:0]  TOKEN_LIMIT_RST  = 4'd8;
    localparam logic [7:0]  OPTION_LIMIT_RST = 8'd16;
    localparam int          OUT_DATA_W     = 80;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [1:0]  msg_type;
        logic [7:0]  msg_code;
        logic [15:0] message_id;
        logic [3:0]  token_length;
        logic [15:0] option_number;
        logic [15:0] option_length;
        logic [7:0]  data_byte;
        logic        done_res;
        t_status     status;
    } t_result;

endpackage

// ===== design/coapmd_cfg.sv =====
// Configuration registers of the CoAP message decoder.
`timescale 1ns / 1ps
module coapmd_cfg
    import coapmd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output logic [3:0] o_token_limit,
    output logic [7:0] o_option_limit
);

    logic [3:0] r_token_limit;
    logic [7:0] r_option_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token_limit  <= TOKEN_LIMIT_RST;
            r_option_limit <= OPTION_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_TOKEN_LIMIT:  r_token_limit  <= i_cfg_data[3:0];
                CFG_OPTION_LIMIT: r_option_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_token_limit  = r_token_limit;
    assign o_option_limit = r_option_limit;

endmodule

// ===== design/coapmd_parser.sv =====
// Per-message parse state and the combinational per-byte step of the decoder.
`timescale 1ns / 1ps
module coapmd_parser
    import coapmd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic [3:0] i_token_limit,
    input  logic [7:0] i_option_limit,
    output t_result    o_result
);

    t_phase      r_phase, n_phase;
    logic [1:0]  r_hdr_cnt, n_hdr_cnt;
    logic [1:0]  r_type, n_type;
    logic [7:0]  r_code, n_code;
    logic [15:0] r_id, n_id;
    logic [3:0]  r_tkl, n_tkl;
    logic [3:0]  r_token_left, n_token_left;
    logic [15:0] r_prev_num, n_prev_num;
    logic [3:0]  r_delta_nib, n_delta_nib;
    logic [3:0]  r_len_nib, n_len_nib;
    logic [15:0] r_ext, n_ext;
    logic [15:0] r_value_left, n_value_left;
    logic [7:0]  r_opt_total, n_opt_total;
    t_status     r_err, n_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEAD;
            r_hdr_cnt    <= '0;
            r_type       <= '0;
            r_code       <= '0;
            r_id         <= '0;
            r_tkl        <= '0;
            r_token_left <= '0;
            r_prev_num   <= '0;
            r_delta_nib  <= '0;
            r_len_nib    <= '0;
            r_ext        <= '0;
            r_value_left <= '0;
            r_opt_total  <= '0;
            r_err        <= ST_OK;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_hdr_cnt    <= n_hdr_cnt;
            r_type       <= n_type;
            r_code       <= n_code;
            r_id         <= n_id;
            r_tkl        <= n_tkl;
            r_token_left <= n_token_left;
            r_prev_num   <= n_prev_num;
            r_delta_nib  <= n_delta_nib;
            r_len_nib    <= n_len_nib;
            r_ext        <= n_ext;
            r_value_left <= n_value_left;
            r_opt_total  <= n_opt_total;
            r_err        <= n_err;
        end
    end

    always_comb begin
        logic        emit;
        t_kind       kind;
        logic        hdr;
        logic [15:0] onum;
        logic [15:0] olen;
        logic [7:0]  data;
        t_status     end_st;
        t_status     status;
        logic        do_adv;
        logic [15:0] adv_d;
        logic        do_fin;
        logic [15:0] fin_len;

        n_phase      = r_phase;
        n_hdr_cnt    = r_hdr_cnt;
        n_type       = r_type;
        n_code       = r_code;
        n_id         = r_id;
        n_tkl        = r_tkl;
        n_token_left = r_token_left;
        n_prev_num   = r_prev_num;
        n_delta_nib  = r_delta_nib;
        n_len_nib    = r_len_nib;
        n_ext        = r_ext;
        n_value_left = r_value_left;
        n_opt_total  = r_opt_total;
        n_err        = r_err;
        emit    = 1'b0;
        kind    = K_STATUS;
        hdr     = 1'b0;
        onum    = '0;
        olen    = '0;
        data    = '0;
        end_st  = ST_OK;
        status  = ST_OK;
        do_adv  = 1'b0;
        adv_d   = '0;
        do_fin  = 1'b0;
        fin_len = '0;

        unique case (r_phase)
            PH_HEAD: begin
                case (r_hdr_cnt)
                    2'd0: begin
                        n_type = i_byte[5:4];
                        n_tkl  = i_byte[3:0];
                        if (i_byte[7:6] != COAP_VERSION) begin
                            if (n_err == ST_OK) n_err = ST_BAD_VERSION;
                        end else if (i_byte[3:0] > i_token_limit) begin
                            if (n_err == ST_OK) n_err = ST_BAD_TOKEN;
                        end
                    end
                    2'd1: n_code = i_byte;
                    2'd2: n_id = {i_byte, 8'h00};
                    default: n_id = {r_id[15:8], i_byte};
                endcase
                if (r_hdr_cnt != 2'd3) begin
                    n_hdr_cnt = r_hdr_cnt + 2'd1;
                    end_st    = ST_TOO_SHORT;
                end else if (n_err != ST_OK) begin
                    n_phase = PH_DRAIN;
                end else begin
                    emit         = 1'b1;
                    kind         = K_HEADER;
                    hdr          = 1'b1;
                    n_token_left = n_tkl;
                    n_phase      = (n_tkl != '0) ? PH_TOKEN : PH_OPT;
                    end_st       = (n_tkl != '0) ? ST_TOO_SHORT : ST_OK;
                end
            end
            PH_TOKEN: begin
                emit         = 1'b1;
                kind         = K_TOKEN;
                data         = i_byte;
                n_token_left = r_token_left - 4'd1;
                if (n_token_left == '0) n_phase = PH_OPT;
                end_st = (n_token_left != '0) ? ST_TOO_SHORT : ST_OK;
            end
            PH_OPT: begin
                if (i_byte == PAYLOAD_MARKER) begin
                    n_phase = PH_PAYLOAD;
                    end_st  = ST_EMPTY_MARK;
                end else begin
                    n_delta_nib = i_byte[7:4];
                    n_len_nib   = i_byte[3:0];
                    if (n_delta_nib == NIBBLE_RSVD || n_len_nib == NIBBLE_RSVD) begin
                        if (n_err == ST_OK) n_err = ST_BAD_OPTION;
                        n_phase = PH_DRAIN;
                    end else if (n_delta_nib >= NIBBLE_EXT8) begin
                        n_phase = PH_DX1;
                        end_st  = ST_TOO_SHORT;
                    end else begin
                        do_adv = 1'b1;
                        adv_d  = {12'd0, n_delta_nib};
                    end
                end
            end
            PH_DX1: begin
                if (r_delta_nib == NIBBLE_EXT8) begin
                    do_adv = 1'b1;
                    adv_d  = EXT8_BASE + {8'd0, i_byte};
                end else begin
                    n_ext   = {i_byte, 8'h00};
                    n_phase = PH_DX2;
                    end_st  = ST_TOO_SHORT;
                end
            end
            PH_DX2: begin
                do_adv = 1'b1;
                adv_d  = EXT16_BASE + {r_ext[15:8], i_byte};
            end
            PH_LX1: begin
                if (r_len_nib == NIBBLE_EXT8) begin
                    do_fin  = 1'b1;
                    fin_len = EXT8_BASE + {8'd0, i_byte};
                end else begin
                    n_ext   = {i_byte, 8'h00};
                    n_phase = PH_LX2;
                    end_st  = ST_TOO_SHORT;
                end
            end
            PH_LX2: begin
                do_fin  = 1'b1;
                fin_len = EXT16_BASE + {r_ext[15:8], i_byte};
            end
            PH_VALUE: begin
                n_value_left = r_value_left - 16'd1;
                if (r_err == ST_OK) begin
                    emit = 1'b1;
                    kind = K_VALUE;
                    data = i_byte;
                end
                if (n_value_left == '0) n_phase = (r_err != ST_OK) ? PH_DRAIN : PH_OPT;
                end_st = (n_value_left != '0) ? ST_TOO_SHORT : ST_OK;
            end
            PH_PAYLOAD: begin
                emit = 1'b1;
                kind = K_PAYLOAD;
                data = i_byte;
            end
            default: ;
        endcase

        if (do_adv) begin
            n_prev_num = r_prev_num + adv_d;
            if (n_len_nib >= NIBBLE_EXT8) begin
                n_phase = PH_LX1;
                end_st  = ST_TOO_SHORT;
            end else begin
                do_fin  = 1'b1;
                fin_len = {12'd0, n_len_nib};
            end
        end

        if (do_fin) begin
            n_value_left = fin_len;
            if (r_opt_total >= i_option_limit) begin
                if (n_err == ST_OK) n_err = ST_TOO_MANY;
                n_phase = (fin_len != '0) ? PH_VALUE : PH_DRAIN;
            end else begin
                n_opt_total = r_opt_total + 8'd1;
                emit        = 1'b1;
                kind        = K_OPTION;
                onum        = n_prev_num;
                olen        = fin_len;
                n_phase     = (fin_len != '0) ? PH_VALUE : PH_OPT;
            end
            end_st = (fin_len != '0) ? ST_TOO_SHORT : ST_OK;
        end

        if (i_last) begin
            status = (end_st != ST_OK) ? end_st : n_err;
            if (status != ST_OK || !emit) begin
                kind = K_STATUS;
                hdr  = 1'b0;
            end
        end

        o_result               = '0;
        o_result.valid         = emit || i_last;
        o_result.kind          = kind;
        o_result.done_res      = i_last;
        o_result.status        = status;
        if (hdr) begin
            o_result.msg_type     = n_type;
            o_result.msg_code     = n_code;
            o_result.message_id   = n_id;
            o_result.token_length = n_tkl;
        end
        if (kind == K_OPTION) begin
            o_result.option_number = onum;
            o_result.option_length = olen;
        end
        if (kind == K_TOKEN || kind == K_VALUE || kind == K_PAYLOAD) begin
            o_result.data_byte = data;
        end

        if (i_last) begin
            n_phase      = PH_HEAD;
            n_hdr_cnt    = '0;
            n_type       = '0;
            n_code       = '0;
            n_id         = '0;
            n_tkl        = '0;
            n_token_left = '0;
            n_prev_num   = '0;
            n_delta_nib  = '0;
            n_len_nib    = '0;
            n_ext        = '0;
            n_value_left = '0;
            n_opt_total  = '0;
            n_err        = ST_OK;
        end
    end

endmodule

// ===== design/coap_message_decoder.sv =====
// Top level of the streaming CoAP message decoder.
// The slave stream takes one message byte per word, with tlast on the final
// byte of each message. The master stream gives one record per word: tuser
// holds the record kind, tdata the record fields and the status, and tlast
// marks the record for the final byte of a message, which carries the status.
// A byte taken sits in the input register and is parsed into the result register
// once that register is free or being read, so its record is offered from the
// result register. Bytes that give no record leave nothing.
// One byte per cycle is taken for as long as the receiver takes records.
// The parse is a single step of the header, option and payload logic per byte.
// When the receiver stalls, the result register holds its record and the input
// register holds one more byte; tready falls once both are full.
// Reset clears both valid flags and the parse state, and sets token_limit to 8
// and option_limit to 16. The user must write configuration on the plain write
// port only while the decoder is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`include "coap_message_decoder_assert.svh"
module coap_message_decoder
    import coapmd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,  // [7:0] in_byte
    input  logic                  i_s_tlast,  // in_last
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [1:0] msg_type, [9:2] msg_code, [25:10] message_id, [29:26] token_length,
    // [45:30] option_number, [61:46] option_length, [69:62] data_byte,
    // [72:70] status, [79:73] zero
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic [2:0]            o_m_tuser,  // [2:0] kind
    output logic                  o_m_tlast,  // done_res
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [7:0]            i_cfg_data
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_res;
    logic       w_adv;
    logic [3:0] w_token_limit;
    logic [7:0] w_option_limit;

    assign w_adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;

    coapmd_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_token_limit  (w_token_limit),
        .o_option_limit (w_option_limit)
    );

    coapmd_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_adv),
        .i_byte         (r_in_byte),
        .i_last         (r_in_last),
        .i_token_limit  (w_token_limit),
        .i_option_limit (w_option_limit),
        .o_result       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_res.valid;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res.valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.done_res;
    assign o_m_tdata  = {7'd0, r_out.status, r_out.data_byte, r_out.option_length,
                         r_out.option_number, r_out.token_length, r_out.message_id,
                         r_out.msg_code, r_out.msg_type};

    `CMD_ASSERT_PROP(a_status_only_kind, (r_out_valid && r_out.status != ST_OK) |-> (r_out.kind == K_STATUS))
    `CMD_ASSERT_PROP(a_status_on_done, (r_out_valid && !r_out.done_res) |-> (r_out.status == ST_OK))
    `CMD_ASSERT_NEVER(a_status_kind_mid, r_out_valid && r_out.kind == K_STATUS && !r_out.done_res)

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the streaming CoAP message decoder.
`timescale 1ns / 1ps
module tb;
    import coapmd_pkg::*;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  mtype;
        logic [7:0]  code;
        logic [15:0] id;
        logic [3:0]  tkl;
        logic [15:0] num;
        logic [15:0] len;
        logic [7:0]  data;
        logic        done;
        t_status     st;
        logic [6:0]  pad;
    } rec_t;

    typedef struct packed {
        logic       last;
        logic [7:0] b;
    } in_word_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata = 8'd0;
    logic                  i_s_tlast = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [2:0]            o_m_tuser;
    logic                  o_m_tlast;
    logic                  i_cfg_we = 1'b0;
    logic [0:0]            i_cfg_index = 1'b0;
    logic [7:0]            i_cfg_data = 8'd0;

    coap_message_decoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    in_word_t    byte_queue[$];
    rec_t        expected_records[$];
    logic [7:0]  build[$];

    int unsigned mismatch_count = 0;
    int unsigned records_checked = 0;
    int unsigned messages_sent = 0;
    int unsigned bytes_queued = 0;
    int unsigned settings_used = 0;
    int unsigned taken_count = 0;
    int unsigned status_seen[0:7];

    logic        s_took = 1'b0;
    logic        rx_hold = 1'b0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    logic [15:0] rx_cycle = 16'd0;
    rec_t        want;
    rec_t        seen;

    // Parse state and register copies of the decoder.
    t_phase      prs_phase;
    logic [1:0]  prs_hdr_cnt;
    logic [1:0]  prs_type;
    logic [7:0]  prs_code;
    logic [15:0] prs_id;
    logic [3:0]  prs_tkl;
    logic [3:0]  prs_tok_left;
    logic [15:0] prs_num;
    logic [3:0]  prs_dnib;
    logic [3:0]  prs_lnib;
    logic [15:0] prs_ext;
    logic [15:0] prs_val_left;
    logic [7:0]  prs_opt_cnt;
    t_status     prs_err;
    logic [3:0]  tok_lim;
    logic [7:0]  opt_lim;

    logic        emit_on;
    t_kind       emit_kind;
    logic [15:0] emit_num;
    logic [15:0] emit_len;
    t_status     emit_end;

    function automatic void clear_parse();
        prs_phase = PH_HEAD;
        prs_hdr_cnt = 2'd0;
        prs_type = 2'd0;
        prs_code = 8'd0;
        prs_id = 16'd0;
        prs_tkl = 4'd0;
        prs_tok_left = 4'd0;
        prs_num = 16'd0;
        prs_dnib = 4'd0;
        prs_lnib = 4'd0;
        prs_ext = 16'd0;
        prs_val_left = 16'd0;
        prs_opt_cnt = 8'd0;
        prs_err = ST_OK;
    endfunction

    function automatic void latch_error(input t_status s);
        if (prs_err == ST_OK) prs_err = s;
    endfunction

    function automatic void close_option(input logic [15:0] len);
        prs_val_left = len;
        if (prs_opt_cnt >= opt_lim) begin
            latch_error(ST_TOO_MANY);
            prs_phase = (len != 16'd0) ? PH_VALUE : PH_DRAIN;
        end else begin
            prs_opt_cnt = prs_opt_cnt + 8'd1;
            emit_on = 1'b1;
            emit_kind = K_OPTION;
            emit_num = prs_num;
            emit_len = len;
            prs_phase = (len != 16'd0) ? PH_VALUE : PH_OPT;
        end
        emit_end = (len != 16'd0) ? ST_TOO_SHORT : ST_OK;
    endfunction

    function automatic void step_number(input logic [15:0] delta);
        prs_num = prs_num + delta;
        if (prs_lnib >= NIBBLE_EXT8) begin
            prs_phase = PH_LX1;
            emit_end = ST_TOO_SHORT;
        end else begin
            close_option({12'd0, prs_lnib});
        end
    endfunction

    function automatic logic decode_byte(input logic [7:0] b, input logic last,
                                         output rec_t r);
        logic    hdr;
        t_status fin;
        hdr = 1'b0;
        fin = ST_OK;
        emit_on = 1'b0;
        emit_kind = K_STATUS;
        emit_num = 16'd0;
        emit_len = 16'd0;
        emit_end = ST_OK;
        r = '0;
        case (prs_phase)
            PH_HEAD: begin
                case (prs_hdr_cnt)
                    2'd0: begin
                        prs_type = b[5:4];
                        prs_tkl = b[3:0];
                        if (b[7:6] != COAP_VERSION) latch_error(ST_BAD_VERSION);
                        else if (b[3:0] > tok_lim) latch_error(ST_BAD_TOKEN);
                    end
                    2'd1: prs_code = b;
                    2'd2: prs_id = {b, 8'h00};
                    default: prs_id[7:0] = b;
                endcase
                if (prs_hdr_cnt != 2'd3) begin
                    prs_hdr_cnt = prs_hdr_cnt + 2'd1;
                    emit_end = ST_TOO_SHORT;
                end else if (prs_err != ST_OK) begin
                    prs_phase = PH_DRAIN;
                end else begin
                    emit_on = 1'b1;
                    emit_kind = K_HEADER;
                    hdr = 1'b1;
                    prs_tok_left = prs_tkl;
                    prs_phase = (prs_tkl != 4'd0) ? PH_TOKEN : PH_OPT;
                    emit_end = (prs_tkl != 4'd0) ? ST_TOO_SHORT : ST_OK;
                end
            end
            PH_TOKEN: begin
                emit_on = 1'b1;
                emit_kind = K_TOKEN;
                prs_tok_left = prs_tok_left - 4'd1;
                if (prs_tok_left == 4'd0) prs_phase = PH_OPT;
                emit_end = (prs_tok_left != 4'd0) ? ST_TOO_SHORT : ST_OK;
            end
            PH_OPT: begin
                if (b == PAYLOAD_MARKER) begin
                    prs_phase = PH_PAYLOAD;
                    emit_end = ST_EMPTY_MARK;
                end else begin
                    prs_dnib = b[7:4];
                    prs_lnib = b[3:0];
                    if (prs_dnib == NIBBLE_RSVD || prs_lnib == NIBBLE_RSVD) begin
                        latch_error(ST_BAD_OPTION);
                        prs_phase = PH_DRAIN;
                    end else if (prs_dnib >= NIBBLE_EXT8) begin
                        prs_phase = PH_DX1;
                        emit_end = ST_TOO_SHORT;
                    end else begin
                        step_number({12'd0, prs_dnib});
                    end
                end
            end
            PH_DX1: begin
                if (prs_dnib == NIBBLE_EXT8) begin
                    step_number(EXT8_BASE + {8'd0, b});
                end else begin
                    prs_ext = {b, 8'h00};
                    prs_phase = PH_DX2;
                    emit_end = ST_TOO_SHORT;
                end
            end
            PH_DX2: step_number(EXT16_BASE + (prs_ext | {8'd0, b}));
            PH_LX1: begin
                if (prs_lnib == NIBBLE_EXT8) begin
                    close_option(EXT8_BASE + {8'd0, b});
                end else begin
                    prs_ext = {b, 8'h00};
                    prs_phase = PH_LX2;
                    emit_end = ST_TOO_SHORT;
                end
            end
            PH_LX2: close_option(EXT16_BASE + (prs_ext | {8'd0, b}));
            PH_VALUE: begin
                prs_val_left = prs_val_left - 16'd1;
                if (prs_err == ST_OK) begin
                    emit_on = 1'b1;
                    emit_kind = K_VALUE;
                end
                if (prs_val_left == 16'd0) prs_phase = (prs_err != ST_OK) ? PH_DRAIN : PH_OPT;
                emit_end = (prs_val_left != 16'd0) ? ST_TOO_SHORT : ST_OK;
            end
            PH_PAYLOAD: begin
                emit_on = 1'b1;
                emit_kind = K_PAYLOAD;
            end
            default: begin
            end
        endcase
        if (last) begin
            fin = (emit_end != ST_OK) ? emit_end : prs_err;
            if (fin != ST_OK || !emit_on) begin
                emit_on = 1'b1;
                emit_kind = K_STATUS;
                hdr = 1'b0;
            end
        end
        if (emit_on) begin
            r.kind = emit_kind;
            if (hdr) begin
                r.mtype = prs_type;
                r.code = prs_code;
                r.id = prs_id;
                r.tkl = prs_tkl;
            end
            if (emit_kind == K_OPTION) begin
                r.num = emit_num;
                r.len = emit_len;
            end
            if (emit_kind == K_TOKEN || emit_kind == K_VALUE || emit_kind == K_PAYLOAD) begin
                r.data = b;
            end
            if (last) begin
                r.done = 1'b1;
                r.st = fin;
                clear_parse();
            end
        end
        return emit_on;
    endfunction

    task automatic print_record(input string tag, input rec_t r);
        $display("  %s kind=%0d type=%0d code=%02h id=%04h tkl=%0d num=%0d len=%0d data=%02h done=%0b status=%0d pad=%0h",
                 tag, r.kind, r.mtype, r.code, r.id, r.tkl, r.num, r.len, r.data, r.done,
                 r.st, r.pad);
    endtask

    // Output check comes before the input prediction so a stray record never meets a
    // prediction made at the same edge.
    always @(posedge i_clk) begin
        s_took <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen.kind = t_kind'(o_m_tuser);
            seen.mtype = o_m_tdata[1:0];
            seen.code = o_m_tdata[9:2];
            seen.id = o_m_tdata[25:10];
            seen.tkl = o_m_tdata[29:26];
            seen.num = o_m_tdata[45:30];
            seen.len = o_m_tdata[61:46];
            seen.data = o_m_tdata[69:62];
            seen.st = t_status'(o_m_tdata[72:70]);
            seen.pad = o_m_tdata[79:73];
            seen.done = o_m_tlast;
            if (expected_records.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("Record %0d arrived with no prediction pending:", records_checked);
                    print_record("actual  ", seen);
                end
                mismatch_count++;
            end else begin
                want = expected_records.pop_front();
                if (want.done) status_seen[want.st]++;
                if (seen !== want) begin
                    if (mismatch_count < 10) begin
                        $display("Record %0d differs from the prediction:", records_checked);
                        print_record("expected", want);
                        print_record("actual  ", seen);
                    end
                    mismatch_count++;
                end
            end
            records_checked++;
        end
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            void'(byte_queue.pop_front());
            taken_count++;
            if (decode_byte(i_s_tdata, i_s_tlast, want)) expected_records.push_back(want);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || s_took) begin
            if (gap_left != 0 && !rx_hold) begin
                gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (byte_queue.size() != 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata <= byte_queue[0].b;
                i_s_tlast <= byte_queue[0].last;
                if (burst_left == 0) burst_left = $urandom_range(1, 40);
                burst_left--;
                if (burst_left == 0) begin
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
            if (hold_left == 0) rx_hold <= 1'b0;
        end else if (!hold_done && taken_count >= 150) begin
            hold_done = 1'b1;
            hold_left = 300;
            rx_hold <= 1'b1;
            i_m_tready <= 1'b0;
        end else begin
            rx_cycle++;
            case (rx_cycle[8:7])
                2'd0: i_m_tready <= 1'b1;
                2'd1: i_m_tready <= ($urandom_range(0, 9) < 7);
                2'd2: i_m_tready <= (rx_cycle[1:0] == 2'd0);
                default: i_m_tready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    task automatic commit_message();
        int i;
        for (i = 0; i < build.size(); i++) begin
            byte_queue.push_back('{last: (i == build.size() - 1), b: build[i]});
        end
        bytes_queued += build.size();
        messages_sent++;
        build.delete();
    endtask

    task automatic add_random_message();
        int          roll;
        int          tkl;
        int          nopt;
        int          dnib;
        int          lnib;
        int          vlen;
        int          cut;
        int          k;
        logic        many;
        logic [1:0]  ver;
        logic [15:0] ext;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            repeat ($urandom_range(1, 12)) build.push_back(8'($urandom));
        end else begin
            tkl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, tok_lim);
            ver = ($urandom_range(0, 19) == 0) ? 2'($urandom) : COAP_VERSION;
            build.push_back({ver, 2'($urandom), 4'(tkl)});
            repeat (3) build.push_back(8'($urandom));
            repeat (tkl) build.push_back(8'($urandom));
            many = ($urandom_range(0, 7) == 0);
            nopt = many ? opt_lim + $urandom_range(1, 2) : $urandom_range(0, 5);
            for (k = 0; k < nopt; k++) begin
                if (many) begin
                    build.push_back({4'($urandom_range(0, 12)), 4'd0});
                end else begin
                    roll = $urandom_range(0, 99);
                    dnib = (roll < 60) ? $urandom_range(0, 12) : (roll < 85) ? 13 :
                           (roll < 99) ? 14 : 15;
                    roll = $urandom_range(0, 99);
                    lnib = (roll < 75) ? $urandom_range(0, 12) : (roll < 90) ? 13 :
                           (roll < 99) ? 14 : 15;
                    build.push_back({4'(dnib), 4'(lnib)});
                    if (dnib == 13) begin
                        build.push_back(8'($urandom));
                    end else if (dnib == 14) begin
                        build.push_back(8'($urandom));
                        build.push_back(8'($urandom));
                    end
                    vlen = lnib;
                    if (lnib == 13) begin
                        ext = 16'($urandom_range(0, 20));
                        build.push_back(ext[7:0]);
                        vlen = 13 + ext;
                    end else if (lnib == 14) begin
                        ext = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 8)) :
                              16'(16'hFEF3 + $urandom_range(0, 30));
                        build.push_back(ext[15:8]);
                        build.push_back(ext[7:0]);
                        vlen = (269 + ext) % 65536;
                    end
                    repeat (vlen) build.push_back(8'($urandom));
                end
            end
            roll = $urandom_range(0, 99);
            if (roll >= 40) begin
                build.push_back(PAYLOAD_MARKER);
                if (roll < 85) repeat ($urandom_range(1, 10)) build.push_back(8'($urandom));
            end
        end
        if ($urandom_range(0, 6) == 0) begin
            cut = $urandom_range(1, build.size());
            while (build.size() > cut) void'(build.pop_back());
        end
        commit_message();
    endtask

    task automatic wait_idle();
        while (byte_queue.size() != 0 || expected_records.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_limits(input logic [3:0] tok, input logic [7:0] opt);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_TOKEN_LIMIT;
        i_cfg_data <= {4'd0, tok};
        @(negedge i_clk);
        i_cfg_index <= CFG_OPTION_LIMIT;
        i_cfg_data <= opt;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tok_lim = tok;
        opt_lim = opt;
        settings_used++;
    endtask

    initial begin
        int          p;
        int unsigned start;
        logic [3:0]  tl;
        logic [7:0]  ol;
        clear_parse();
        tok_lim = TOKEN_LIMIT_RST;
        opt_lim = OPTION_LIMIT_RST;
        for (p = 0; p < 8; p++) status_seen[p] = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        settings_used = 1;

        build = '{8'h40};
        commit_message();
        build = '{8'h00, 8'h01};
        commit_message();
        build = '{8'h4F, 8'h01, 8'h00, 8'h00, 8'h11};
        commit_message();
        build = '{8'h52, 8'h45, 8'h12, 8'h34, 8'hA5, 8'h5A, 8'hFF};
        commit_message();
        build = '{8'h60, 8'h01, 8'h00, 8'h01, 8'hF0, 8'h00};
        commit_message();
        build = '{8'h40, 8'hFF, 8'hFF, 8'hFF, 8'hEE, 8'hFF, 8'hFF, 8'hFE, 8'hF3,
                  8'hD1, 8'h00, 8'hAA, 8'hFF, 8'h00};
        commit_message();
        build = '{8'h40, 8'h00, 8'h00, 8'h00, 8'hD2};
        commit_message();
        wait_idle();

        for (p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    tl = 4'd15;
                    ol = 8'd255;
                end
                1: begin
                    tl = 4'd0;
                    ol = 8'd0;
                end
                2: begin
                    tl = 4'd3;
                    ol = 8'd1;
                end
                3: begin
                    tl = TOKEN_LIMIT_RST;
                    ol = OPTION_LIMIT_RST;
                end
                4: begin
                    tl = 4'($urandom);
                    ol = 8'($urandom_range(0, 24));
                end
                default: begin
                    tl = 4'($urandom);
                    ol = 8'($urandom);
                end
            endcase
            set_limits(tl, ol);
            start = bytes_queued;
            while (bytes_queued - start < 85) add_random_message();
            wait_idle();
        end

        while (byte_queue.size() != 0 || expected_records.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        $display("Checked %0d records from %0d messages (%0d bytes) under %0d register settings.",
                 records_checked, messages_sent, bytes_queued, settings_used);
        $display("Final status counts, ok through too_many_options: %0d %0d %0d %0d %0d %0d %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6]);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatching or unexpected records.", mismatch_count);
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d bytes unsent and %0d records outstanding.",
                 byte_queue.size(), expected_records.size());
        $display("DONE: errors detected");
        $finish;
    end
endmodule
